@@ hdl/byte_budget_lru_directory_assert.svh @@
// assertion macros for the lru directory module
// no dependencies
`ifndef BYTE_BUDGET_LRU_DIRECTORY_ASSERT_SVH
`define BYTE_BUDGET_LRU_DIRECTORY_ASSERT_SVH

// implication checked every cycle outside reset
`define BBLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define BBLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bbld_pkg.sv @@
// package for the byte budget lru directory: commands, status codes, register indexes
// no dependencies
package bbld_pkg;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_PUT = 2'd1;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  // status field of an eviction notice
  localparam logic [2:0] ST_NOTICE   = 3'd0;

  // result kind, carried on tuser
  localparam logic KIND_FINAL = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  localparam logic REG_BUDGET = 1'b0;
  localparam logic REG_MAX    = 1'b1;

  localparam int SIZE_BITS = 24;

  // command from the sequencer to the cell chain
  typedef struct packed {
    logic match_en;   // latch per-cell hit flag against bus key
    logic promote;    // cells younger than bus rank age by one, hit cell to zero
    logic write_size; // hit cell takes bus size
    logic evict;      // cell of oldest rank drops out
    logic insert;     // valid cells age by one, first free cell takes bus
  } bbld_ctl_t;

endpackage

@@ hdl/bbld_cell.sv @@
// one directory cell: key, size, valid bit and recency rank
// depends on bbld_pkg
module bbld_cell
  import bbld_pkg::*;
#(
  parameter int KEY_BITS  = 64,
  parameter int RANK_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bbld_ctl_t             ctl,
  input  logic [KEY_BITS-1:0]   bus_key,
  input  logic [SIZE_BITS-1:0]  bus_size,
  input  logic [RANK_BITS-1:0]  bus_rank,
  input  logic [RANK_BITS-1:0]  oldest_rank,
  input  logic                  free_in,   // some earlier cell is free
  output logic                  free_out,
  output logic                  hit,
  output logic                  valid,
  output logic [KEY_BITS-1:0]   key,
  output logic [SIZE_BITS-1:0]  size,
  output logic [RANK_BITS-1:0]  rank
);

  logic take;

  // free chain runs through the row, first free cell takes an insert
  assign free_out = free_in | ~valid;
  assign take     = ~valid & ~free_in;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
      hit   <= 1'b0;
    end else begin
      if (ctl.match_en) hit <= valid && key == bus_key;
      if (ctl.promote && valid) begin
        if (hit) rank <= '0;
        else if (rank < bus_rank) rank <= rank + 1'b1;
      end
      if (ctl.evict && valid && rank == oldest_rank) valid <= 1'b0;
      if (ctl.insert) begin
        if (valid) rank <= rank + 1'b1;
        else if (take) begin
          valid <= 1'b1;
          rank  <= '0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if ((ctl.insert && take) || (ctl.write_size && hit && valid)) size <= bus_size;
    if (ctl.insert && take) key <= bus_key;
  end

endmodule

@@ hdl/byte_budget_lru_directory.sv @@
// Byte budget LRU directory. One request is taken at a time. A get, a statistics
// read, an update or a rejected put runs from accept through a match state, where
// every cell compares the key, and a decide state, which reduces the hit and
// decides, to a final state that loads the result into the output register. A put
// of a new key passes an evict state first, which emits an eviction notice via the
// emit state or inserts; evict and final wait while the output register is full.
// The cells compare and re-rank in parallel; the oldest entry is found by the rank
// that equals the live count minus one. Depends on bbld_pkg and bbld_cell.
`include "byte_budget_lru_directory_assert.svh"
module byte_budget_lru_directory
  import bbld_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], key[65:2], entry_bytes[89:66], zero pad
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], hit_bytes[26:3], evicted_key[90:27], evicted_bytes[114:91],
  // live_entries[119:115], used_bytes[151:120]
  output logic [151:0] m_axis_tdata,
  // kind[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_DECIDE, S_EVICT, S_EMIT, S_FINAL} state_t;

  state_t state;
  logic [31:0] budget;
  logic [SIZE_BITS-1:0] max_bytes;
  logic [1:0] cmd;
  logic [KEY_BITS-1:0] req_key;
  logic [SIZE_BITS-1:0] req_size;
  logic [32:0] total;
  logic [CNT_BITS-1:0] count;
  logic [2:0] fin_status;
  logic [SIZE_BITS-1:0] fin_hit;

  bbld_ctl_t ctl, ctl_next;
  logic [ENTRIES-1:0] hit_v, valid_v;
  logic [ENTRIES:0] free_c;
  logic [KEY_BITS-1:0] key_v [ENTRIES];
  logic [SIZE_BITS-1:0] size_v [ENTRIES];
  logic [RANK_BITS-1:0] rank_v [ENTRIES];
  logic [RANK_BITS-1:0] oldest_rank, hit_rank;
  logic [SIZE_BITS-1:0] hit_size, old_size;
  logic [KEY_BITS-1:0] old_key;
  logic any_hit;

  // cell row
  assign free_c[0] = 1'b0;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bbld_cell #(.KEY_BITS(KEY_BITS), .RANK_BITS(RANK_BITS)) u_cell (
      .clk, .rst, .ctl, .bus_key(req_key), .bus_size(req_size), .bus_rank(hit_rank),
      .oldest_rank, .free_in(free_c[g]), .free_out(free_c[g+1]), .hit(hit_v[g]),
      .valid(valid_v[g]), .key(key_v[g]), .size(size_v[g]), .rank(rank_v[g]));
  end

  assign oldest_rank = RANK_BITS'(count - 1'b1);

  // select hit cell and oldest cell (one-hot selects)
  always_comb begin
    hit_size = '0; hit_rank = '0; old_key = '0; old_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_v[i] && valid_v[i]) begin
        hit_size = hit_size | size_v[i];
        hit_rank = hit_rank | rank_v[i];
      end
      if (valid_v[i] && rank_v[i] == oldest_rank) begin
        old_key  = old_key | key_v[i];
        old_size = old_size | size_v[i];
      end
    end
  end
  assign any_hit = |(hit_v & valid_v);

  logic need_evict;
  logic put_ok;
  logic [32:0] ev_total;
  logic [31:0] used_now, used_ev;

  assign need_evict = count != 0 &&
    ((total + 33'(req_size) > {1'b0, budget}) || count >= CNT_BITS'(ENTRIES));
  assign put_ok = req_size != '0 && req_size <= max_bytes && 32'(req_size) <= budget;

  // byte totals for the result fields, saturating
  assign ev_total = total - 33'(old_size);
  assign used_now = total[32] ? 32'hFFFFFFFF : total[31:0];
  assign used_ev  = ev_total[32] ? 32'hFFFFFFFF : ev_total[31:0];

  assign s_axis_tready = state == S_IDLE;

  // cell commands for the next cycle
  always_comb begin
    ctl_next = '0;
    case (state)
      S_IDLE: ctl_next.match_en = s_axis_tvalid;
      S_DECIDE: begin
        if (cmd == CMD_GET) begin
          ctl_next.promote = any_hit;
        end else if (cmd == CMD_PUT && put_ok && any_hit) begin
          ctl_next.promote    = 1'b1;
          ctl_next.write_size = 1'b1;
        end
      end
      S_EVICT: if (!m_axis_tvalid) begin
        ctl_next.evict  = need_evict;
        ctl_next.insert = ~need_evict;
      end
      default: ctl_next = '0;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
      state <= S_IDLE;
      budget <= 32'd10485760;
      max_bytes <= 24'd1048576;
      total <= '0;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      ctl <= ctl_next;
      if (cfg_we) begin
        if (cfg_index == REG_BUDGET) budget <= cfg_data;
        else max_bytes <= cfg_data[SIZE_BITS-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd      <= s_axis_tdata[1:0];
          req_key  <= s_axis_tdata[2 +: KEY_BITS];
          req_size <= s_axis_tdata[66 +: SIZE_BITS];
          state    <= S_MATCH;
        end
        S_MATCH: state <= S_DECIDE;
        S_DECIDE: begin
          if (cmd == CMD_GET) begin
            fin_status <= any_hit ? ST_HIT : ST_MISS;
            fin_hit    <= any_hit ? hit_size : '0;
            state      <= S_FINAL;
          end else if (cmd != CMD_PUT) begin
            fin_status <= ST_HIT;
            fin_hit    <= '0;
            state      <= S_FINAL;
          end else if (!put_ok) begin
            fin_status <= ST_REJECTED;
            fin_hit    <= '0;
            state      <= S_FINAL;
          end else if (any_hit) begin
            fin_status <= ST_UPDATED;
            fin_hit    <= '0;
            total      <= total - 33'(hit_size) + 33'(req_size);
            state      <= S_FINAL;
          end else begin
            fin_status <= ST_INSERTED;
            fin_hit    <= '0;
            state      <= S_EVICT;
          end
        end
        S_EVICT: if (!m_axis_tvalid) begin
          if (need_evict) begin
            m_axis_tdata <= {used_ev, 5'(count - 1'b1), old_size, 64'(old_key),
                             24'd0, ST_NOTICE};
            m_axis_tuser <= KIND_EVICT;
            m_axis_tlast <= 1'b0;
            m_axis_tvalid <= 1'b1;
            total <= ev_total;
            state <= S_EMIT;
          end else begin
            total <= total + 33'(req_size);
            count <= count + 1'b1;
            state <= S_FINAL;
          end
        end
        // cell drops out this cycle against the rank of the old count
        S_EMIT: begin
          count <= count - 1'b1;
          state <= S_EVICT;
        end
        S_FINAL: if (!m_axis_tvalid) begin
          m_axis_tdata <= {used_now, 5'(count), 24'd0, 64'd0, fin_hit, fin_status};
          m_axis_tuser <= KIND_FINAL;
          m_axis_tlast <= 1'b1;
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BBLD_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_BITS'(ENTRIES), "count above depth")
  `BBLD_ASSERT_IMP(a_live_matches, state == S_IDLE, $countones(valid_v) == 32'(count),
                   "valid bits disagree with count")
  `BBLD_ASSERT_IMP(a_one_hit, 1'b1, $onehot0(hit_v & valid_v), "key held twice")
  `BBLD_ASSERT_NEXT(a_evict_drops, ctl.evict, $countones(valid_v) == 32'(count),
                    "eviction did not drop one cell")

endmodule

@@ verif/byte_budget_lru_directory_tb.sv @@
// testbench for byte_budget_lru_directory: a queue-fed stream driver, an lru predictor
// and a monitor that checks every result transfer field by field; depends on bbld_pkg
module byte_budget_lru_directory_tb
  import bbld_pkg::*;
();

  localparam int NSLOTS = 16;
  localparam logic [1:0] CMD_STATS = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [23:0] nbytes;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [23:0] hit_bytes;
    logic [63:0] ev_key;
    logic [23:0] ev_bytes;
    logic [4:0]  live;
    logic [31:0] used;
    logic        last;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_BUDGET;
  logic [31:0]  cfg_data = '0;

  byte_budget_lru_directory dut (.*);

  always #10 clk = ~clk;

  // directory mirror
  logic [63:0] dir_key [NSLOTS];
  logic [23:0] dir_size[NSLOTS];
  logic        dir_live[NSLOTS];
  int unsigned dir_rank[NSLOTS];
  logic [63:0] dir_total;
  int unsigned dir_count;
  logic [31:0] lim_budget;
  logic [23:0] lim_entry;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  request_t offered;
  int idle_pct = 0, stall_pct = 0;
  int hold_left = 0;
  bit hold_go = 0;
  int errors = 0;
  int quiet_cycles = 0;
  logic [63:0] key_pool[24];

  function automatic outcome_t mk(logic kind, logic [2:0] st, logic [23:0] hb,
                                  logic [63:0] ek, logic [23:0] eb, logic lst);
    outcome_t o;
    o.kind = kind; o.status = st; o.hit_bytes = hb; o.ev_key = ek; o.ev_bytes = eb;
    o.live = dir_count[4:0];
    o.used = (dir_total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dir_total[31:0];
    o.last = lst;
    return o;
  endfunction

  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < NSLOTS; i++)
      if (dir_live[i] && dir_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void make_recent(int s);
    for (int i = 0; i < NSLOTS; i++)
      if (dir_live[i] && dir_rank[i] < dir_rank[s]) dir_rank[i]++;
    dir_rank[s] = 0;
  endfunction

  // work out the result transfers one request causes
  function automatic void apply_request(request_t r);
    int s, v;
    if (r.cmd == CMD_GET) begin
      s = find_key(r.key);
      if (s < 0) expected_outcomes.push_back(mk(KIND_FINAL, ST_MISS, '0, '0, '0, 1'b1));
      else begin
        make_recent(s);
        expected_outcomes.push_back(mk(KIND_FINAL, ST_HIT, dir_size[s], '0, '0, 1'b1));
      end
      return;
    end
    if (r.cmd != CMD_PUT) begin
      expected_outcomes.push_back(mk(KIND_FINAL, ST_HIT, '0, '0, '0, 1'b1));
      return;
    end
    if (r.nbytes == 0 || r.nbytes > lim_entry || {8'd0, r.nbytes} > lim_budget) begin
      expected_outcomes.push_back(mk(KIND_FINAL, ST_REJECTED, '0, '0, '0, 1'b1));
      return;
    end
    s = find_key(r.key);
    if (s >= 0) begin
      dir_total = dir_total - dir_size[s] + r.nbytes;
      dir_size[s] = r.nbytes;
      make_recent(s);
      expected_outcomes.push_back(mk(KIND_FINAL, ST_UPDATED, '0, '0, '0, 1'b1));
      return;
    end
    // evict the oldest until bytes and a slot are free
    while (dir_count > 0 &&
           (dir_total + r.nbytes > {32'd0, lim_budget} || dir_count >= NSLOTS)) begin
      v = -1;
      for (int i = 0; i < NSLOTS; i++)
        if (dir_live[i] && (v < 0 || dir_rank[i] > dir_rank[v])) v = i;
      dir_live[v] = 1'b0;
      dir_total -= dir_size[v];
      dir_count--;
      expected_outcomes.push_back(mk(KIND_EVICT, ST_NOTICE, '0, dir_key[v], dir_size[v],
                                     1'b0));
    end
    s = -1;
    for (int i = 0; i < NSLOTS; i++)
      if (!dir_live[i] && s < 0) s = i;
    if (s >= 0) begin
      for (int i = 0; i < NSLOTS; i++)
        if (dir_live[i]) dir_rank[i]++;
      dir_live[s] = 1'b1; dir_key[s] = r.key; dir_size[s] = r.nbytes; dir_rank[s] = 0;
      dir_total += r.nbytes;
      dir_count++;
    end
    expected_outcomes.push_back(mk(KIND_FINAL, ST_INSERTED, '0, '0, '0, 1'b1));
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_request(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          offered = pending_reqs.pop_front();
          s_axis_tdata <= {6'd0, offered.nbytes, offered.key, offered.cmd};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_go) begin
        hold_left = 400;
        hold_go = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[26:3],
               m_axis_tdata[90:27], m_axis_tdata[114:91], m_axis_tlast);
      got.live = m_axis_tdata[119:115];
      got.used = m_axis_tdata[151:120];
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer %h", $time, got);
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          errors++;
          $display(
            "%0t: expected kind %0d st %0d hit %0d evk %h evb %0d live %0d used %0d last %0d",
            $time, want.kind, want.status, want.hit_bytes, want.ev_key,
            want.ev_bytes, want.live, want.used, want.last);
          $display(
            "%0t:   actual kind %0d st %0d hit %0d evk %h evb %0d live %0d used %0d last %0d",
            $time, got.kind, got.status, got.hit_bytes, got.ev_key,
            got.ev_bytes, got.live, got.used, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == REG_BUDGET) lim_budget = val;
    else lim_entry = val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_req(logic [1:0] c, logic [63:0] k, logic [23:0] n);
    request_t r;
    r.cmd = c; r.key = k; r.nbytes = n;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
      @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // random requests, mostly on a small key pool so hits and updates happen
  task automatic random_reqs(int n, int unsigned szmax);
    int unsigned p;
    logic [1:0] c;
    logic [63:0] k;
    logic [23:0] sz;
    for (int j = 0; j < n; j++) begin
      p = $urandom_range(99);
      c = (p < 45) ? CMD_PUT : (p < 80) ? CMD_GET : (p < 95) ? CMD_STATS : CMD_SPARE;
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : {$urandom, $urandom};
      p = $urandom_range(19);
      if (p == 0) sz = '0;
      else if (p == 1) sz = (szmax >= 24'hFFFFFF) ? 24'hFFFFFF : 24'(szmax + 1);
      else if (p == 2) sz = 24'($urandom);
      else sz = 24'($urandom_range(szmax, 1));
      queue_req(c, k, sz);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      dir_live[i] = 1'b0; dir_rank[i] = 0; dir_key[i] = '0; dir_size[i] = '0;
    end
    dir_total = '0; dir_count = 0;
    lim_budget = 32'd10485760; lim_entry = 24'd1048576;
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: hits, misses, updates, rejects, statistics and the spare command
    queue_req(CMD_GET, key_pool[0], 24'd7);
    queue_req(CMD_PUT, key_pool[0], 24'd1000);
    queue_req(CMD_GET, key_pool[0], 24'd0);
    queue_req(CMD_PUT, key_pool[0], 24'd2000);
    queue_req(CMD_PUT, key_pool[1], 24'd0);
    queue_req(CMD_PUT, key_pool[1], 24'd1048577);
    queue_req(CMD_STATS, key_pool[0], 24'hFFFFFF);
    queue_req(CMD_SPARE, '1, 24'd5);
    queue_req(CMD_PUT, '1, 24'd1048576);
    queue_req(CMD_PUT, '0, 24'd1);
    queue_req(CMD_GET, '0, 24'd0);
    queue_req(CMD_GET, '1, 24'd0);
    drain();

    // size above the budget, then full table and byte evictions
    write_reg(REG_MAX, 32'h00FF_FFFF);
    write_reg(REG_BUDGET, 32'd3000000);
    queue_req(CMD_PUT, key_pool[2], 24'd4000000);
    for (int i = 0; i < 14; i++) queue_req(CMD_PUT, key_pool[4 + i], 24'(i + 1));
    queue_req(CMD_PUT, key_pool[3], 24'd2999000);
    drain();

    // lowered budget: update in place leaves it over, a new key evicts
    write_reg(REG_BUDGET, 32'd100);
    queue_req(CMD_PUT, key_pool[3], 24'd50);
    queue_req(CMD_PUT, key_pool[20], 24'd60);
    drain();

    write_reg(REG_BUDGET, 32'd5000);
    write_reg(REG_MAX, 32'd2000);
    random_reqs(40, 2000);
    drain();

    idle_pct = 57;
    random_reqs(35, 2000);
    drain();

    write_reg(REG_BUDGET, 32'hFFFF_FFFF);
    write_reg(REG_MAX, 32'h00FF_FFFF);
    idle_pct = 0; stall_pct = 57;
    random_reqs(35, 24'hFFFFFF);
    drain();

    // receiver holds off while requests keep coming
    write_reg(REG_BUDGET, 32'd40000);
    idle_pct = 22; stall_pct = 22;
    hold_go = 1;
    random_reqs(40, 6000);
    drain();

    write_reg(REG_BUDGET, 32'd0);
    write_reg(REG_MAX, 32'd0);
    idle_pct = 0; stall_pct = 0;
    random_reqs(8, 100);
    drain();

    write_reg(REG_BUDGET, 32'd20000);
    write_reg(REG_MAX, 32'd3000);
    random_reqs(40, 3000);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
